// ===== rtl/dndf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and control types for the decimal number display formatter.
// Depends on nothing; used by the controller, the datapath and the top level.
package dndf_pkg;

   localparam int VALUE_WIDTH   = 16;
   localparam int FIELD_WIDTH   = 16;
   localparam int VALUE_USED_W  = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
   localparam int BITS_PER_STEP = 2;
   localparam int CONV_CYCLES   = (VALUE_USED_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int BIN_W         = CONV_CYCLES * BITS_PER_STEP;
   localparam int CONV_CNT_W    = (CONV_CYCLES > 1) ? $clog2(CONV_CYCLES) : 1;

   function automatic int digits_for(input int width);
      longint unsigned m;
      int n;
      m = (longint'(1) << width) - 1;
      n = 1;
      while (m >= 10) begin
         m = m / 10;
         n = n + 1;
      end
      return n;
   endfunction

   localparam int NUM_DIGITS  = digits_for(VALUE_USED_W);
   localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   localparam logic [7:0] LINE1_BASE = 8'h80;
   localparam logic [7:0] LINE2_BASE = 8'hC0;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [1:0] LINE_ONE   = 2'd1;
   localparam logic [1:0] LINE_TWO   = 2'd2;
   localparam logic [4:0] MAX_COLUMN = 5'd15;

   typedef struct packed {
      logic load;
      logic step;
      logic find;
      logic advance;
   } dndf_cmd_type;

   typedef struct packed {
      logic last;
   } dndf_status_type;

endpackage

// ===== rtl/dndf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the display formatter: sequences load, conversion and output.
// Depends on dndf_pkg for the command and status types.
module dndf_ctrl
   import dndf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  dndf_status_type sts,
   output dndf_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [CONV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (cnt_ff == CONV_CNT_W'(CONV_CYCLES - 1)) begin
               state_in = ST_FIND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               cmd.advance = 1'b1;
               if (sts.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);

endmodule

// ===== rtl/dndf_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the display formatter: shift-and-add-3 converter, digit pointer
// and the cursor command register. Depends on dndf_pkg.
module dndf_datapath
   import dndf_pkg::*;
(
   input  logic            clock,
   input  logic [15:0]     value,
   input  logic [1:0]      line,
   input  logic [4:0]      column,
   input  dndf_cmd_type    cmd,
   output dndf_status_type sts,
   output logic            reg_select,
   output logic [7:0]      code
);

   logic [BIN_W-1:0]                  bin_ff, bin_in;
   logic [NUM_DIGITS-1:0][3:0]        bcd_ff, bcd_in;
   logic                              pend_ff, pend_in;
   logic [7:0]                        cmd_code_ff, cmd_code_in;
   logic [DIGIT_IDX_W-1:0]            idx_ff, idx_in;
   logic [NUM_DIGITS-1:0][3:0]        bcd_step;
   logic [BIN_W-1:0]                  bin_step;
   logic [DIGIT_IDX_W-1:0]            top_idx;
   logic                              cursor_ok;

   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d] >= 4'd5) begin
               bcd_step[d] = bcd_step[d] + 4'd3;
            end
         end
         bcd_step = (NUM_DIGITS*4)'({bcd_step, bin_step[BIN_W-1]});
         bin_step = {bin_step[BIN_W-2:0], 1'b0};
      end
   end

   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d] != 4'd0) begin
            top_idx = DIGIT_IDX_W'(d);
         end
      end
   end

   assign cursor_ok = (column <= MAX_COLUMN) && ((line == LINE_ONE) || (line == LINE_TWO));

   always_comb begin
      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      pend_in     = pend_ff;
      cmd_code_in = cmd_code_ff;
      idx_in      = idx_ff;
      if (cmd.load) begin
         bin_in      = BIN_W'(value[VALUE_USED_W-1:0]);
         bcd_in      = '0;
         pend_in     = cursor_ok;
         cmd_code_in = ((line == LINE_ONE) ? LINE1_BASE : LINE2_BASE) | {4'd0, column[3:0]};
      end
      if (cmd.step) begin
         bin_in = bin_step;
         bcd_in = bcd_step;
      end
      if (cmd.find) begin
         idx_in = top_idx;
      end
      if (cmd.advance) begin
         if (pend_ff) begin
            pend_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      pend_ff     <= pend_in;
      cmd_code_ff <= cmd_code_in;
      idx_ff      <= idx_in;
   end

   assign sts.last   = !pend_ff && (idx_ff == '0);
   assign reg_select = !pend_ff;
   assign code       = pend_ff ? cmd_code_ff : (ASCII_ZERO | {4'd0, bcd_ff[idx_ff]});

endmodule

// ===== rtl/decimal_number_display_formatter.sv =====
`timescale 1ns / 1ps
// Top level of the decimal number display formatter: controller plus datapath.
// Depends on dndf_pkg, dndf_ctrl and dndf_datapath.
//
//   Channel   Direction  Contents
//   req_*     in         tdata: value[15:0], line[17:16], column[22:18], zero pad
//   rsp_*     out        tdata: code; tuser: reg_select; tlast: last
//
// A request is accepted in idle, then converted by shift-and-add-3 two bits per
// cycle, and then the leading digit is located. Each of the one to six results
// is then shown in turn, and a stalled result holds.
// Reset returns the controller to idle; no request is taken while results remain.
module decimal_number_display_formatter
   import dndf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // value[15:0], line[17:16], column[22:18], zero[23]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // code[7:0]
   output logic        rsp_tuser,   // reg_select[0]
   output logic        rsp_tlast
);

   dndf_cmd_type    cmd;
   dndf_status_type sts;

   dndf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dndf_datapath u_datapath (
      .clock      (clock),
      .value      (req_tdata[15:0]),
      .line       (req_tdata[17:16]),
      .column     (req_tdata[22:18]),
      .cmd        (cmd),
      .sts        (sts),
      .reg_select (rsp_tuser),
      .code       (rsp_tdata)
   );

   assign rsp_tlast = sts.last;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while results are pending");

   a_cmd_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> !rsp_tlast)
      else $error("cursor command flagged as last");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata >= ASCII_ZERO && rsp_tdata <= 8'h39))
      else $error("character outside decimal digits");

   a_conv_gap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result shown before conversion");

endmodule

// ===== test/dndf_display_checker.sv =====
`timescale 1ns / 1ps
// Checker for the decimal number display formatter: watches both streams, predicts the
// cursor command and ASCII digit bytes of each request and compares them in order.
// Depends on dndf_pkg for the line codes, the command bases and the used value width.
module dndf_display_checker
   import dndf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // value[15:0], line[17:16], column[22:18], zero[23]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // code[7:0]
   input  logic        rsp_tuser,   // reg_select[0]
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic       reg_select;
      logic [7:0] code;
      logic       last;
   } lcd_byte_type;

   lcd_byte_type display_bytes_due[$];
   lcd_byte_type due;
   int           error_total = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_total++;
      if (error_total <= 100) begin
         $display("%0t dndf_display_checker: %s: got 0x%0h, expected 0x%0h",
                  $time, what, got, want);
      end
   endtask

   function automatic void queue_display_bytes(input logic [15:0] value,
                                               input logic [1:0]  line,
                                               input logic [4:0]  column);
      int unsigned  n;
      int           count;
      logic [7:0]   digit_chars[10];
      lcd_byte_type b;
      n = value;
      if (VALUE_USED_W < 16) begin
         n = n % (32'd1 << VALUE_USED_W);
      end
      count = 0;
      do begin
         digit_chars[count] = ASCII_ZERO + 8'(n % 10);
         count++;
         n = n / 10;
      end while (n != 0 && count < 10);
      if (column <= MAX_COLUMN && (line == LINE_ONE || line == LINE_TWO)) begin
         b.reg_select = 1'b0;
         b.code       = ((line == LINE_ONE) ? LINE1_BASE : LINE2_BASE) + {3'b000, column};
         b.last       = 1'b0;
         display_bytes_due.push_back(b);
      end
      while (count > 0) begin
         count--;
         b.reg_select = 1'b1;
         b.code       = digit_chars[count];
         b.last       = (count == 0);
         display_bytes_due.push_back(b);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         display_bytes_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            queue_display_bytes(req_tdata[15:0], req_tdata[17:16], req_tdata[22:18]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (display_bytes_due.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_tdata, 0);
            end else begin
               due = display_bytes_due.pop_front();
               if (rsp_tuser !== due.reg_select) begin
                  report_mismatch("reg_select", rsp_tuser, due.reg_select);
               end
               if (rsp_tdata !== due.code) begin
                  report_mismatch("code", rsp_tdata, due.code);
               end
               if (rsp_tlast !== due.last) begin
                  report_mismatch("last", rsp_tlast, due.last);
               end
            end
         end
      end
      outstanding <= display_bytes_due.size();
      mismatches  <= error_total;
   end

endmodule

// ===== test/tb_decimal_number_display_formatter.sv =====
`timescale 1ns / 1ps
// Testbench top for the decimal number display formatter: drives directed and random
// requests with random idling and back-pressure, and gives the verdict.
// Depends on decimal_number_display_formatter, dndf_pkg and dndf_display_checker.
module tb_decimal_number_display_formatter;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_STALL  = 300;
   localparam int RANDOM_REQS = 348;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // value[15:0], line[17:16], column[22:18], zero[23]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // code[7:0]
   logic        rsp_tuser;   // reg_select[0]
   logic        rsp_tlast;
   logic        idle_en;
   int          stall_requests;
   int          mismatches;
   int          outstanding;

   decimal_number_display_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dndf_display_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : response_sink
      int hold_left;
      int stalls_done;
      hold_left   = 0;
      stalls_done = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_requests != stalls_done) begin
            stalls_done = stall_requests;
            hold_left   = LONG_STALL;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_en) begin
            rsp_tready <= ($urandom_range(0, 99) >= 27);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_decimal_number_display_formatter: FAIL");
      $finish;
   end

   task automatic offer_request(input logic [15:0] value, input logic [1:0] line,
                                input logic [4:0] column);
      while (idle_en && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, column, line, value};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_value();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 9));
         1:       return 16'($urandom_range(10, 99));
         2:       return 16'($urandom_range(100, 999));
         3:       return 16'($urandom_range(1000, 9999));
         4:       return 16'($urandom_range(10000, 65535));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [4:0] random_column();
      if ($urandom_range(0, 99) < 70) begin
         return 5'($urandom_range(0, 15));
      end
      return 5'($urandom_range(16, 31));
   endfunction

   initial begin : stimulus
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      idle_en        = 1'b1;
      stall_requests = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      offer_request(16'd0,     2'd1, 5'd0);
      offer_request(16'd65535, 2'd2, 5'd15);
      offer_request(16'd9,     2'd0, 5'd3);
      offer_request(16'd10,    2'd3, 5'd7);
      offer_request(16'd99,    2'd1, 5'd16);
      offer_request(16'd100,   2'd2, 5'd31);
      offer_request(16'd999,   2'd1, 5'd15);
      offer_request(16'd1000,  2'd2, 5'd0);
      offer_request(16'd9999,  2'd1, 5'd8);
      offer_request(16'd10000, 2'd2, 5'd1);
      offer_request(16'd43690, 2'd1, 5'd10);
      offer_request(16'd21845, 2'd2, 5'd5);
      offer_request(16'd32768, 2'd3, 5'd20);
      offer_request(16'd1,     2'd0, 5'd31);
      offer_request(16'd65535, 2'd0, 5'd0);
      offer_request(16'd0,     2'd3, 5'd16);
      offer_request(16'd12345, 2'd1, 5'd31);
      offer_request(16'd60000, 2'd2, 5'd12);
      offer_request(16'd5,     2'd2, 5'd15);
      offer_request(16'd255,   2'd1, 5'd14);

      // Hold the response side off while requests keep coming, so the block backs up.
      stall_requests <= stall_requests + 1;
      repeat (12) offer_request(random_value(), 2'($urandom_range(0, 3)), random_column());
      wait_for_results();

      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == 120) begin
            idle_en <= 1'b0;
         end
         if (i == 200) begin
            idle_en <= 1'b1;
         end
         if (i == 260) begin
            wait_for_results();
         end
         offer_request(random_value(), 2'($urandom_range(0, 3)), random_column());
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_decimal_number_display_formatter: PASS");
      end else begin
         $display("tb_decimal_number_display_formatter: FAIL");
      end
      $finish;
   end

endmodule
